// ===== rtl/slac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_pkg
// Shared widths, the line shift reset value and the memory control bundle for the
// set-associative LRU cache lookup unit.
// ----------------------------------------------------------------------------
package slac_pkg;

    localparam int ADDR_W    = 48;
    localparam int LINE_W    = 48;
    localparam int RANK_W    = 4;
    localparam int WAY_OUT_W = 4;
    localparam int CNT_W     = 32;
    localparam int SHIFT_W   = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd6;

    // Control from the lookup sequencer to the set memories.
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic meta_we;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== rtl/set_associative_lru_cache_model_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_associative_lru_cache_model_unit
// Set-associative cache lookup with LRU replacement and saturating
// hit and miss totals.
// ----------------------------------------------------------------------------
// The result strobe comes from r_strobe, registered from r_pend, which is registered from accept.
// A new address is taken only once the previous one's set row has been read from
//   memory and its valid bits, ranks and (on a miss) tags have been written back.
// Reset: clears totals and sets line_shift to 6, then sweeps the valid/rank
//   memory with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_model_unit
    import slac_pkg::*;
#(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SHIFT_W-1:0]   i_cfg_line_shift,
    output logic                      o_result_valid,
    output logic                      o_hit,
    output logic      [WAY_OUT_W-1:0] o_way,
    output logic      [CNT_W-1:0]     o_hit_total,
    output logic      [CNT_W-1:0]     o_miss_total
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [SHIFT_W-1:0]   r_line_shift;
    logic                 r_pend;
    logic [LINE_W-1:0]    r_line;
    logic [SET_W-1:0]     r_set;
    logic                 r_strobe;
    logic                 r_hit;
    logic [WAY_OUT_W-1:0] r_way;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;

    logic                 accept;
    logic [LINE_W-1:0]    n_line;
    logic [SET_W-1:0]     n_set;
    t_mem_ctl             mem_ctl;
    logic                 clearing;

    logic [WAYS-1:0][LINE_W-1:0] rd_tags;
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][RANK_W-1:0] rd_ranks;
    logic [WAYS-1:0][LINE_W-1:0] wr_tags;
    logic [WAYS-1:0]             wr_valid;
    logic [WAYS-1:0][RANK_W-1:0] wr_ranks;
    logic                        lk_hit;
    logic [WAY_W-1:0]            lk_way;

    assign busy        = r_pend || clearing;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign n_line = LINE_W'(i_address >> r_line_shift);
    assign n_set  = SET_W'(n_line & LINE_W'(SETS - 1));

    always_comb begin
        mem_ctl.rd_en   = accept;
        mem_ctl.tag_we  = r_pend && !lk_hit;
        mem_ctl.meta_we = r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift <= SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_shift <= i_cfg_line_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line <= n_line;
            r_set  <= n_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            r_pend   <= accept;
            r_strobe <= r_pend;
            if (r_pend) begin
                if (lk_hit && (r_hit_cnt != '1)) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end
                if (!lk_hit && (r_miss_cnt != '1)) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_hit <= lk_hit;
            r_way <= WAY_OUT_W'(lk_way);
        end
    end

    slac_store #(
        .WAYS  (WAYS),
        .SETS  (SETS),
        .SET_W (SET_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_rd_set   (n_set),
        .i_wr_set   (r_set),
        .i_wr_tags  (wr_tags),
        .i_wr_valid (wr_valid),
        .i_wr_ranks (wr_ranks),
        .o_rd_tags  (rd_tags),
        .o_rd_valid (rd_valid),
        .o_rd_ranks (rd_ranks),
        .o_clearing (clearing)
    );

    slac_lru #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_lru (
        .i_line  (r_line),
        .i_tags  (rd_tags),
        .i_valid (rd_valid),
        .i_ranks (rd_ranks),
        .o_hit   (lk_hit),
        .o_way   (lk_way),
        .o_tags  (wr_tags),
        .o_valid (wr_valid),
        .o_ranks (wr_ranks)
    );

    assign o_result_valid = r_strobe;
    assign o_hit          = r_hit;
    assign o_way          = r_way;
    assign o_hit_total    = r_hit_cnt;
    assign o_miss_total   = r_miss_cnt;

    // An accepted beat blocks the next one until its set is written back.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !start || busy)
        else $error("accept not followed by busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_result_valid)
        else $error("result strobe missing after accept");

    a_miss_keeps_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_hit |-> o_hit_total == $past(o_hit_total))
        else $error("hit total moved on a miss");

    a_hit_keeps_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_hit |-> o_miss_total == $past(o_miss_total))
        else $error("miss total moved on a hit");

endmodule

`default_nettype wire

// ===== rtl/slac_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_store
// Set memories: one row per set holding all tags, and one row per set holding
// valid bits and recency ranks. Reads are registered. The metadata
// memory is swept to zero after reset, one set per cycle.
// ----------------------------------------------------------------------------
module slac_store
    import slac_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int SETS  = 64,
    parameter int SET_W = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_mem_ctl                          i_ctl,
    input  wire logic [SET_W-1:0]                  i_rd_set,
    input  wire logic [SET_W-1:0]                  i_wr_set,
    input  wire logic [WAYS-1:0][LINE_W-1:0]       i_wr_tags,
    input  wire logic [WAYS-1:0]                   i_wr_valid,
    input  wire logic [WAYS-1:0][RANK_W-1:0]       i_wr_ranks,
    output logic      [WAYS-1:0][LINE_W-1:0]       o_rd_tags,
    output logic      [WAYS-1:0]                   o_rd_valid,
    output logic      [WAYS-1:0][RANK_W-1:0]       o_rd_ranks,
    output logic                                   o_clearing
);

    localparam int META_W = WAYS * (RANK_W + 1);

    logic [WAYS-1:0][LINE_W-1:0] r_tag_mem [SETS];
    logic [META_W-1:0]           r_meta_mem [SETS];
    logic [META_W-1:0]           r_rd_meta;

    logic             r_clearing;
    logic [SET_W-1:0] r_clr_idx;

    logic             meta_we;
    logic [SET_W-1:0] meta_addr;
    logic [META_W-1:0] meta_wdata;

    // Clear sweep over the metadata memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == SET_W'(SETS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_comb begin
        if (r_clearing) begin
            meta_we    = 1'b1;
            meta_addr  = r_clr_idx;
            meta_wdata = '0;
        end else begin
            meta_we    = i_ctl.meta_we;
            meta_addr  = i_wr_set;
            meta_wdata = {i_wr_valid, i_wr_ranks};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tag_we) begin
            r_tag_mem[i_wr_set] <= i_wr_tags;
        end
        if (i_ctl.rd_en) begin
            o_rd_tags <= r_tag_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_addr] <= meta_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_meta <= r_meta_mem[i_rd_set];
        end
    end

    assign o_rd_valid = r_rd_meta[META_W-1 -: WAYS];
    assign o_rd_ranks = r_rd_meta[WAYS*RANK_W-1:0];
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== rtl/slac_lru.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_lru
// Tag compare, victim choice and recency update for one set row.
// ----------------------------------------------------------------------------
module slac_lru
    import slac_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int WAY_W = 2
) (
    input  wire logic [LINE_W-1:0]              i_line,
    input  wire logic [WAYS-1:0][LINE_W-1:0]    i_tags,
    input  wire logic [WAYS-1:0]                i_valid,
    input  wire logic [WAYS-1:0][RANK_W-1:0]    i_ranks,
    output logic                                o_hit,
    output logic      [WAY_W-1:0]               o_way,
    output logic      [WAYS-1:0][LINE_W-1:0]    o_tags,
    output logic      [WAYS-1:0]                o_valid,
    output logic      [WAYS-1:0][RANK_W-1:0]    o_ranks
);

    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   oldest;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  lru_way;
    logic              any_inv;
    logic              was_valid;
    logic [RANK_W-1:0] old_rank;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            match[i]  = i_valid[i] && (i_tags[i] == i_line);
            // Ranks of a full set are a permutation, so the top rank is unique.
            oldest[i] = (i_ranks[i] == RANK_W'(WAYS - 1));
        end
    end

    // Lowest index wins in each search.
    always_comb begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WAY_W'(i);
            end
            if (!i_valid[i]) begin
                inv_way = WAY_W'(i);
            end
            if (oldest[i]) begin
                lru_way = WAY_W'(i);
            end
        end
    end

    assign o_hit   = |match;
    assign any_inv = ~&i_valid;

    always_comb begin
        if (o_hit) begin
            o_way = hit_way;
        end else if (any_inv) begin
            o_way = inv_way;
        end else begin
            o_way = lru_way;
        end
    end

    assign was_valid = o_hit || !any_inv;
    assign old_rank  = i_ranks[o_way];

    // Promote the touched way; age more recent valid ways, or all on a fill.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            o_tags[i] = i_tags[i];
            if (WAY_W'(i) == o_way) begin
                o_ranks[i] = '0;
                o_valid[i] = 1'b1;
                if (!o_hit) begin
                    o_tags[i] = i_line;
                end
            end else begin
                o_valid[i] = i_valid[i];
                if (i_valid[i] && (!was_valid || (i_ranks[i] < old_rank))) begin
                    o_ranks[i] = i_ranks[i] + 1'b1;
                end else begin
                    o_ranks[i] = i_ranks[i];
                end
            end
        end
    end

endmodule

`default_nettype wire
